/* design/assert_macros.svh */
// Assertion macros shared by the deviation rank engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, quiet while rst_n is low.
`define DRE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define DRE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/dre_pkg.sv */
// Types and constants of the deviation rank engine.
package dre_pkg;

    localparam int SIZE    = 64;
    localparam int ADDR_W  = $clog2(SIZE);
    localparam int CNT_W   = $clog2(SIZE + 1);
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [23:0] estimate;
        logic               last_item;
    } in_item_t;

    typedef struct packed {
        logic [5:0] element_index;
        logic [5:0] rank;
        logic       last_result;
    } out_item_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic signed [23:0] estimate;
        logic [ADDR_W-1:0]  addr;
        logic               keep;
        logic               last;
        logic [CNT_W-1:0]   set_size;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef enum logic {
        BK_LOAD,
        BK_RANK
    } back_state_t;

endpackage

/* design/dre_front.sv */
// Front end: takes requests, tracks the set fill and tags each request.
module dre_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  dre_pkg::in_item_t request,
    input  dre_pkg::q_stat_t  q_stat,
    output logic              push,
    output dre_pkg::cmd_t     cmd
);
    import dre_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             keep;

    assign push = start && !q_stat.full;
    assign keep = cnt_reg < CNT_W'(SIZE);

    always_comb
    begin
        cmd.estimate = request.estimate;
        cmd.addr     = cnt_reg[ADDR_W-1:0];
        cmd.keep     = keep;
        cmd.last     = request.last_item;
        cmd.set_size = keep ? cnt_reg + CNT_W'(1) : cnt_reg;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push)
        begin
            if (request.last_item)
                cnt_next = '0;
            else
                cnt_next = cmd.set_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

/* design/dre_queue.sv */
// Short command queue between front and back.
module dre_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dre_pkg::cmd_t    push_data,
    input  logic             pop,
    output dre_pkg::cmd_t    pop_data,
    output dre_pkg::q_stat_t q_stat
);
    import dre_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign pop_data     = slot_reg[rptr_reg];
    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == QCNT_W'(QDEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= ptr_inc(wptr_reg);
            if (pop)
                rptr_reg <= ptr_inc(rptr_reg);
            if (push && !pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

endmodule

/* design/dre_back.sv */
// Back end: estimate store, rank sweep and result register.
module dre_back (
    input  logic               clk,
    input  logic               rst_n,
    input  dre_pkg::q_stat_t   q_stat,
    input  dre_pkg::cmd_t      q_data,
    output logic               pop,
    input  logic               cfg_we,
    input  logic signed [23:0] cfg_data,
    output logic               done,
    output dre_pkg::out_item_t result
);
    import dre_pkg::*;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic signed [23:0] centre_reg;

    logic [ADDR_W-1:0]  i_reg;
    logic [ADDR_W-1:0]  j_reg;
    logic [CNT_W-1:0]   n_reg;
    logic               issue;
    logic               j_last;
    logic               i_last;

    logic signed [23:0] mem [SIZE];
    logic signed [23:0] rd_a_reg;
    logic signed [23:0] rd_b_reg;

    logic               s1_valid_reg;
    logic [ADDR_W-1:0]  s1_i_reg;
    logic [ADDR_W-1:0]  s1_j_reg;
    logic               s1_jlast_reg;
    logic               s1_ilast_reg;

    logic               s2_valid_reg;
    logic [ADDR_W-1:0]  s2_i_reg;
    logic [ADDR_W-1:0]  s2_j_reg;
    logic               s2_jlast_reg;
    logic               s2_ilast_reg;
    logic [23:0]        dist_a_reg;
    logic [23:0]        dist_b_reg;

    logic               hit;
    logic [ADDR_W-1:0]  acc_reg;
    logic [ADDR_W-1:0]  acc_sum;
    logic               done_reg;
    out_item_t          result_reg;

    // |est - centre|, exact: always below 2^24
    function automatic logic [23:0] abs_dist(input logic signed [23:0] est,
                                             input logic signed [23:0] ctr);
        logic signed [24:0] diff;
        logic signed [24:0] mag;
        diff     = 25'(est) - 25'(ctr);
        mag      = diff[24] ? -diff : diff;
        abs_dist = mag[23:0];
    endfunction

    assign j_last = (CNT_W'(j_reg) == n_reg - CNT_W'(1));
    assign i_last = (CNT_W'(i_reg) == n_reg - CNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_LOAD:
            begin
                if (!q_stat.empty && q_data.last)
                    state_next = BK_RANK;
            end
            BK_RANK:
            begin
                if (j_last && i_last)
                    state_next = BK_LOAD;
            end
            default: state_next = BK_LOAD;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop   = 1'b0;
        issue = 1'b0;
        unique case (state_reg)
            BK_LOAD: pop   = !q_stat.empty;
            BK_RANK: issue = 1'b1;
            default:
            begin
                pop   = 1'b0;
                issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_LOAD;
            centre_reg <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            n_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                centre_reg <= cfg_data;
            if (pop && q_data.last)
            begin
                n_reg <= q_data.set_size;
                i_reg <= '0;
                j_reg <= '0;
            end
            else if (issue)
            begin
                if (j_last)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + ADDR_W'(1);
                end
                else
                    j_reg <= j_reg + ADDR_W'(1);
            end
        end
    end

    // estimate store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (pop && q_data.keep)
            mem[q_data.addr] <= q_data.estimate;
        rd_a_reg <= mem[i_reg];
        rd_b_reg <= mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        s1_i_reg     <= i_reg;
        s1_j_reg     <= j_reg;
        s1_jlast_reg <= j_last;
        s1_ilast_reg <= i_last;
        s2_i_reg     <= s1_i_reg;
        s2_j_reg     <= s1_j_reg;
        s2_jlast_reg <= s1_jlast_reg;
        s2_ilast_reg <= s1_ilast_reg;
        dist_a_reg   <= abs_dist(rd_a_reg, centre_reg);
        dist_b_reg   <= abs_dist(rd_b_reg, centre_reg);
        if (s2_valid_reg && s2_jlast_reg)
        begin
            result_reg.element_index <= 6'(s2_i_reg);
            result_reg.rank          <= 6'(acc_sum);
            result_reg.last_result   <= s2_ilast_reg;
        end
    end

    // ties go to the lower index
    assign hit = (dist_b_reg < dist_a_reg) ||
                 ((dist_b_reg == dist_a_reg) && (s2_j_reg < s2_i_reg));
    assign acc_sum = acc_reg + ADDR_W'(hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg && s2_jlast_reg;
            if (s2_valid_reg)
                acc_reg <= s2_jlast_reg ? '0 : acc_sum;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* design/deviation_rank_engine.sv */
// A request that ends a set starts the rank sweep, which gives one result per stored element
// in index order (n = set size); no queued request is popped while the sweep runs.
// Each result costs one pass of the compare unit over all n stored deviations.
// Requests are accepted whenever the queue has room; up to two can wait there during a sweep.
// Reset (rst_n low, asynchronous) empties the queue, clears the set and sets centre to 0.
// Results are shown for one cycle on done; the receiver cannot stall them.
`include "assert_macros.svh"

module deviation_rank_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dre_pkg::in_item_t  request,
    input  logic               cfg_we,
    input  logic signed [23:0] cfg_data,
    output logic               done,
    output dre_pkg::out_item_t result
);
    import dre_pkg::*;

    // Front classifies each request (store slot, overflow drop, set size so far).
    // The queue lets loading carry on while the back end is still sweeping a set.
    q_stat_t q_stat;
    logic    push;
    logic    pop;
    cmd_t    push_cmd;
    cmd_t    pop_cmd;

    // Busy only when the queue is full
    assign busy = q_stat.full;

    dre_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .q_stat  (q_stat),
        .push    (push),
        .cmd     (push_cmd)
    );

    dre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .q_stat    (q_stat)
    );

    // Back end: writes the store, then per element sweeps all n entries,
    // counting closer ones (ties to lower index) through a three-stage pipe.
    dre_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_data   (pop_cmd),
        .pop      (pop),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    // An accepted request is never lost: the queue holds something afterwards
    `DRE_ASSERT(a_accept_queued, (start && !busy) |=> !q_stat.empty, "accepted request not queued")
    // The final result of a set cannot be followed at once by another
    `DRE_ASSERT(a_last_gap, (done && result.last_result) |=> !done, "result right after final result")
    // No result strobe straight out of reset
    `DRE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !done, "result strobe after reset")

endmodule
